/* sv/byte_credit_fifo_unit_assert.svh */
// ----------------------------------------------------------------------------
// byte_credit_fifo_unit assertion macros
// Short forms for the concurrent checks of the descriptor queue.
// ----------------------------------------------------------------------------
`ifndef BYTE_CREDIT_FIFO_UNIT_ASSERT_SVH
`define BYTE_CREDIT_FIFO_UNIT_ASSERT_SVH

// cond holds at every edge outside reset
`define BCF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons holds at the same edge as ante
`define BCF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons holds at the edge after ante
`define BCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bcf_pkg.sv */
// ----------------------------------------------------------------------------
// bcf_pkg
// Types, codes and helpers of the byte credit descriptor queue.
// ----------------------------------------------------------------------------
package bcf_pkg;

   localparam int DATA_WIDTH         = 32;
   localparam int SLOT_COUNT_DEFAULT = 16;

   localparam logic [DATA_WIDTH-1:0] NO_LIMIT_CREDIT = 32'hFFFF_FFFF;

   // request opcodes
   localparam logic [1:0] OPC_PUT    = 2'd0;
   localparam logic [1:0] OPC_GET    = 2'd1;
   localparam logic [1:0] OPC_STATUS = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_CREDIT = 2'd1;
   localparam logic [1:0] ST_NO_SLOT   = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] id;
      logic [DATA_WIDTH-1:0] op;
      logic [DATA_WIDTH-1:0] handle;
      logic [DATA_WIDTH-1:0] length;
   } entry_type;

   // credit left for a given capacity and held byte total
   function automatic logic [DATA_WIDTH-1:0] credit_of(
      input logic [DATA_WIDTH-1:0] capacity,
      input logic [DATA_WIDTH-1:0] bytes
   );
      logic [DATA_WIDTH-1:0] result;
      if (capacity == '0) begin
         result = NO_LIMIT_CREDIT;
      end else if (bytes > capacity) begin
         result = '0;
      end else begin
         result = capacity - bytes;
      end
      return result;
   endfunction

endpackage

/* sv/byte_credit_fifo_unit.sv */
// ----------------------------------------------------------------------------
// byte_credit_fifo_unit
// Descriptor queue with a byte credit limit on admission.
// ----------------------------------------------------------------------------
//
//   channel   ports                      handshake
//   -------   ------------------------   -----------------------------------
//   request   start, busy, req_*         word taken when start && !busy
//   response  rsp_valid, rsp_*           one-cycle strobe, cannot be held off
//   config    csr_valid, csr_ready, csr  word taken when csr_valid && ready
//
// A request word is taken every cycle; busy never rises. Each word passes
// through the input register, then the decision logic that loads the
// response register. The rate is set by the head register, which always
// holds the oldest descriptor read ahead from the slot memory, so a get
// never waits on a memory read.
// Reset is synchronous and clears pointers, count, byte total and capacity;
// the slot memory needs no clearing pass. There is no stall on either side.
// ----------------------------------------------------------------------------
`include "byte_credit_fifo_unit_assert.svh"

module byte_credit_fifo_unit import bcf_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
   localparam int PtrWidth   = $clog2(SLOT_COUNT),
   localparam int CountWidth = $clog2(SLOT_COUNT + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [DATA_WIDTH-1:0] req_entry_id,
   input  logic [DATA_WIDTH-1:0] req_entry_op,
   input  logic [DATA_WIDTH-1:0] req_entry_handle,
   input  logic [DATA_WIDTH-1:0] req_entry_length,
   // response channel
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_out_id,
   output logic [DATA_WIDTH-1:0] rsp_out_op,
   output logic [DATA_WIDTH-1:0] rsp_out_handle,
   output logic [DATA_WIDTH-1:0] rsp_out_length,
   output logic [CountWidth-1:0] rsp_entry_count,
   output logic [DATA_WIDTH-1:0] rsp_credit_left,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [DATA_WIDTH-1:0] csr_byte_capacity
);

   localparam logic [PtrWidth-1:0]   LastSlot  = PtrWidth'(SLOT_COUNT - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(SLOT_COUNT);

   function automatic logic [PtrWidth-1:0] next_slot(input logic [PtrWidth-1:0] ptr);
      return (ptr == LastSlot) ? '0 : ptr + PtrWidth'(1);
   endfunction

   // configuration
   logic [DATA_WIDTH-1:0] capacity_ff;

   // input register
   logic                  req_valid_ff;
   logic [1:0]            opcode_ff;
   entry_type             req_entry_ff;

   // queue state
   logic [PtrWidth-1:0]   rptr_ff, rptr_in;
   logic [PtrWidth-1:0]   wptr_ff, wptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [DATA_WIDTH-1:0] bytes_ff, bytes_in;

   // slot memory and read-ahead head register
   entry_type             desc_mem_ff [SLOT_COUNT];
   entry_type             head_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   entry_type             rsp_entry_ff;
   logic [CountWidth-1:0] rsp_count_ff;
   logic [DATA_WIDTH-1:0] rsp_credit_ff;
   logic                  rsp_empty_ff;
   logic                  rsp_full_ff;

   // decision logic
   logic                  limited;
   logic [DATA_WIDTH-1:0] credit_cur;
   logic [DATA_WIDTH-1:0] credit_put;
   logic [DATA_WIDTH-1:0] bytes_after_get;
   logic [DATA_WIDTH-1:0] credit_get;
   logic                  short_credit;
   logic                  put_ok;
   logic [1:0]            status_in;
   entry_type             out_entry_in;
   logic [DATA_WIDTH-1:0] credit_in;

   // a new word every cycle; config is always taken
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_byte_capacity;
      end
   end

   // capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff           <= req_opcode;
      req_entry_ff.id     <= req_entry_id;
      req_entry_ff.op     <= req_entry_op;
      req_entry_ff.handle <= req_entry_handle;
      req_entry_ff.length <= req_entry_length;
   end

   // credit paths run side by side, the opcode picks one
   assign limited         = (capacity_ff != '0);
   assign credit_cur      = credit_of(capacity_ff, bytes_ff);
   assign short_credit    = limited && (req_entry_ff.length > credit_cur);
   assign credit_put      = limited ? (credit_cur - req_entry_ff.length) : NO_LIMIT_CREDIT;
   assign bytes_after_get = bytes_ff - head_ff.length;
   assign credit_get      = credit_of(capacity_ff, bytes_after_get);

   always_comb begin
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      count_in     = count_ff;
      bytes_in     = bytes_ff;
      put_ok       = 1'b0;
      status_in    = ST_OK;
      out_entry_in = '0;
      credit_in    = credit_cur;
      if (req_valid_ff) begin
         case (opcode_ff)
            OPC_PUT: begin
               if (short_credit) begin
                  status_in = ST_NO_CREDIT;
               end else if (count_ff == FullCount) begin
                  status_in = ST_NO_SLOT;
               end else begin
                  put_ok    = 1'b1;
                  wptr_in   = next_slot(wptr_ff);
                  count_in  = count_ff + CountWidth'(1);
                  bytes_in  = bytes_ff + req_entry_ff.length;
                  credit_in = credit_put;
               end
            end
            OPC_GET: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  out_entry_in = head_ff;
                  rptr_in      = next_slot(rptr_ff);
                  count_in     = count_ff - CountWidth'(1);
                  bytes_in     = bytes_after_get;
                  credit_in    = credit_get;
               end
            end
            default: begin
               // status only: report state, change nothing
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff  <= '0;
         wptr_ff  <= '0;
         count_ff <= '0;
         bytes_ff <= '0;
      end else begin
         rptr_ff  <= rptr_in;
         wptr_ff  <= wptr_in;
         count_ff <= count_in;
         bytes_ff <= bytes_in;
      end
   end

   // write the slot at the write pointer on an admitted put
   always_ff @(posedge clock) begin
      if (put_ok) begin
         desc_mem_ff[wptr_ff] <= req_entry_ff;
      end
   end

   // read ahead at the next read pointer; forward a put to that same slot
   always_ff @(posedge clock) begin
      if (put_ok && (wptr_ff == rptr_in)) begin
         head_ff <= req_entry_ff;
      end else begin
         head_ff <= desc_mem_ff[rptr_in];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= status_in;
      rsp_entry_ff  <= out_entry_in;
      rsp_count_ff  <= count_in;
      rsp_credit_ff <= credit_in;
      rsp_empty_ff  <= (count_in == '0);
      rsp_full_ff   <= limited && (credit_in == '0);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_entry_ff.id;
   assign rsp_out_op      = rsp_entry_ff.op;
   assign rsp_out_handle  = rsp_entry_ff.handle;
   assign rsp_out_length  = rsp_entry_ff.length;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_credit_left = rsp_credit_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

   // checks
   `BCF_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FullCount,
      "entry count beyond slot count")
   `BCF_ASSERT_IMPLIES(a_empty_ptrs, clock, reset, count_ff == '0, rptr_ff == wptr_ff,
      "empty queue with pointers apart")
   `BCF_ASSERT_NEXT(a_word_responds, clock, reset, req_valid_ff, rsp_valid_ff,
      "request word gave no response")
   `BCF_ASSERT_IMPLIES(a_reject_no_data, clock, reset,
      rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_entry_ff == '0,
      "rejected word carries descriptor data")

endmodule

/* tb/sv/byte_credit_fifo_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_credit_fifo_unit_checker
// Watches the request, response and capacity channels, keeps its own copy
// of the descriptor queue and its byte credit, and compares every response
// word field by field with the response it computes.
// ----------------------------------------------------------------------------
module byte_credit_fifo_unit_checker import bcf_pkg::*; #(
   parameter int SLOTS   = SLOT_COUNT_DEFAULT,
   parameter int COUNT_W = $clog2(SLOTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [DATA_WIDTH-1:0] req_entry_id,
   input  logic [DATA_WIDTH-1:0] req_entry_op,
   input  logic [DATA_WIDTH-1:0] req_entry_handle,
   input  logic [DATA_WIDTH-1:0] req_entry_length,
   input  logic                  rsp_valid,
   input  logic [1:0]            rsp_status,
   input  logic [DATA_WIDTH-1:0] rsp_out_id,
   input  logic [DATA_WIDTH-1:0] rsp_out_op,
   input  logic [DATA_WIDTH-1:0] rsp_out_handle,
   input  logic [DATA_WIDTH-1:0] rsp_out_length,
   input  logic [COUNT_W-1:0]    rsp_entry_count,
   input  logic [DATA_WIDTH-1:0] rsp_credit_left,
   input  logic                  rsp_is_empty,
   input  logic                  rsp_is_full,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [DATA_WIDTH-1:0] csr_byte_capacity,
   output int                    mismatch_count,
   output int                    words_due
);

   typedef struct packed {
      logic [1:0]            status;
      entry_type             desc;
      logic [COUNT_W-1:0]    count;
      logic [DATA_WIDTH-1:0] credit;
      logic                  empty;
      logic                  full;
   } queue_rsp_type;

   logic [DATA_WIDTH-1:0] capacity;
   logic [DATA_WIDTH-1:0] bytes_held;
   entry_type             held_q[$];
   queue_rsp_type         due_q[$];

   function automatic logic [DATA_WIDTH-1:0] remaining_credit();
      logic [DATA_WIDTH-1:0] left;
      if (capacity == '0) begin
         left = NO_LIMIT_CREDIT;
      end else if (bytes_held > capacity) begin
         left = '0;
      end else begin
         left = capacity - bytes_held;
      end
      return left;
   endfunction

   // advance the queue copy by one request word and return its response
   function automatic queue_rsp_type apply_request(logic [1:0] opc, entry_type d);
      queue_rsp_type r;
      r = '0;
      r.status = ST_OK;
      case (opc)
         OPC_PUT: begin
            if (capacity != '0 && d.length > remaining_credit()) begin
               r.status = ST_NO_CREDIT;
            end else if (held_q.size() >= SLOTS) begin
               r.status = ST_NO_SLOT;
            end else begin
               held_q.push_back(d);
               bytes_held = bytes_held + d.length;
            end
         end
         OPC_GET: begin
            if (held_q.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.desc = held_q.pop_front();
               bytes_held = bytes_held - r.desc.length;
            end
         end
         default: ;
      endcase
      r.count  = COUNT_W'(held_q.size());
      r.credit = remaining_credit();
      r.empty  = (held_q.size() == 0);
      r.full   = (capacity != '0) && (r.credit == '0);
      return r;
   endfunction

   function automatic void check_field(string name, logic [DATA_WIDTH-1:0] want,
                                       logic [DATA_WIDTH-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      queue_rsp_type want;
      entry_type     taken;
      if (reset) begin
         capacity       = '0;
         bytes_held     = '0;
         mismatch_count = 0;
         held_q.delete();
         due_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            capacity = csr_byte_capacity;
         end
         if (rsp_valid) begin
            if (due_q.size() == 0) begin
               $error("response word with none expected");
               mismatch_count++;
            end else begin
               want = due_q.pop_front();
               check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(rsp_status));
               check_field("out_id", want.desc.id, rsp_out_id);
               check_field("out_op", want.desc.op, rsp_out_op);
               check_field("out_handle", want.desc.handle, rsp_out_handle);
               check_field("out_length", want.desc.length, rsp_out_length);
               check_field("entry_count", DATA_WIDTH'(want.count),
                           DATA_WIDTH'(rsp_entry_count));
               check_field("credit_left", want.credit, rsp_credit_left);
               check_field("is_empty", DATA_WIDTH'(want.empty), DATA_WIDTH'(rsp_is_empty));
               check_field("is_full", DATA_WIDTH'(want.full), DATA_WIDTH'(rsp_is_full));
            end
         end
         if (start && !busy) begin
            taken.id     = req_entry_id;
            taken.op     = req_entry_op;
            taken.handle = req_entry_handle;
            taken.length = req_entry_length;
            due_q.push_back(apply_request(req_opcode, taken));
         end
      end
      words_due <= due_q.size();
   end

endmodule

/* tb/sv/byte_credit_fifo_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_credit_fifo_unit_tb
// Drives request words and capacity writes into the descriptor queue; a
// checker beside the block predicts each response and counts mismatches.
// ----------------------------------------------------------------------------
module byte_credit_fifo_unit_tb;
   import bcf_pkg::*;

   localparam int SLOTS       = SLOT_COUNT_DEFAULT;
   localparam int COUNT_W     = $clog2(SLOTS + 1);
   localparam int PHASE_WORDS = 255;
   localparam int CYCLE_LIMIT = 400000;
   // opcode with no operation behind it; answered like a status request
   localparam logic [1:0] OPC_SPARE = 2'd3;
   localparam logic [DATA_WIDTH-1:0] ALL_ONES = 32'hFFFF_FFFF;

   logic                  clock;
   logic                  reset             = 1'b1;
   logic                  start             = 1'b0;
   logic [1:0]            req_opcode        = OPC_STATUS;
   logic [DATA_WIDTH-1:0] req_entry_id      = '0;
   logic [DATA_WIDTH-1:0] req_entry_op      = '0;
   logic [DATA_WIDTH-1:0] req_entry_handle  = '0;
   logic [DATA_WIDTH-1:0] req_entry_length  = '0;
   logic                  csr_valid         = 1'b0;
   logic [DATA_WIDTH-1:0] csr_byte_capacity = '0;

   logic                  busy;
   logic                  rsp_valid;
   logic [1:0]            rsp_status;
   logic [DATA_WIDTH-1:0] rsp_out_id;
   logic [DATA_WIDTH-1:0] rsp_out_op;
   logic [DATA_WIDTH-1:0] rsp_out_handle;
   logic [DATA_WIDTH-1:0] rsp_out_length;
   logic [COUNT_W-1:0]    rsp_entry_count;
   logic [DATA_WIDTH-1:0] rsp_credit_left;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic                  csr_ready;

   int mismatch_count;
   int words_due;
   int idle_pct   = 0;
   int cycle_count = 0;

   byte_credit_fifo_unit #(.SLOT_COUNT(SLOTS)) u_top (.*);

   byte_credit_fifo_unit_checker #(.SLOTS(SLOTS), .COUNT_W(COUNT_W)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost response ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[byte_credit_fifo_unit] ERROR");
         $finish;
      end
   end

   // Present one request word and hold it until taken. Keep start high
   // when the next word follows at once; drop it only for an idle gap.
   task automatic send_word(logic [1:0] opc, logic [DATA_WIDTH-1:0] id,
                            logic [DATA_WIDTH-1:0] xop, logic [DATA_WIDTH-1:0] handle,
                            logic [DATA_WIDTH-1:0] len);
      start            <= 1'b1;
      req_opcode       <= opc;
      req_entry_id     <= id;
      req_entry_op     <= xop;
      req_entry_handle <= handle;
      req_entry_length <= len;
      do @(posedge clock); while (busy);
      if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // hold off the sender until every response word has come out
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   // capacity changes only with the block idle; drain first, then let the input and response registers settle
   task automatic write_capacity(logic [DATA_WIDTH-1:0] cap);
      drain();
      repeat (4) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_byte_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly small lengths, with zero, full-range and all-ones mixed in
   function automatic logic [DATA_WIDTH-1:0] pick_length();
      int r;
      r = $urandom_range(99, 0);
      if (r < 10) return '0;
      if (r < 20) return $urandom;
      if (r < 25) return ALL_ONES;
      return $urandom_range(300, 1);
   endfunction

   task automatic send_random(logic [1:0] opc);
      send_word(opc, $urandom, $urandom, $urandom, pick_length());
   endtask

   // Bursts of puts and gets walk the queue between empty and full;
   // a share of mixed words adds status and spare opcodes as noise.
   task automatic random_phase(logic [DATA_WIDTH-1:0] cap, int pct);
      int sent;
      int kind;
      int run;
      write_capacity(cap);
      idle_pct = pct;
      sent = 0;
      while (sent < PHASE_WORDS) begin
         kind = $urandom_range(99, 0);
         run  = $urandom_range(20, 1);
         if ($urandom_range(99, 0) < 5) begin
            drain();
         end
         repeat (run) begin
            if (kind < 40) begin
               send_random(OPC_PUT);
            end else if (kind < 80) begin
               send_random(OPC_GET);
            end else begin
               send_random(2'($urandom_range(3, 0)));
            end
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, no limit: status, get on empty, spare opcode
      send_word(OPC_STATUS, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_word(OPC_GET, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_word(OPC_SPARE, '0, '0, '0, '0);
      // no limit: byte total wraps past 2^32
      send_word(OPC_PUT, ALL_ONES, '0, ALL_ONES, ALL_ONES);
      send_word(OPC_PUT, '0, ALL_ONES, '0, 32'd2);
      send_word(OPC_GET, '0, '0, '0, '0);
      send_word(OPC_GET, '0, '0, '0, '0);

      // put over the capacity, exact fit, zero length at no credit, short credit
      write_capacity(32'd100);
      send_word(OPC_PUT, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'd101);
      send_word(OPC_PUT, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666, 32'd100);
      send_word(OPC_PUT, 32'h7777_7777, 32'h8888_8888, 32'h9999_9999, 32'd0);
      send_word(OPC_PUT, 32'hAAAA_AAAA, 32'hBBBB_BBBB, 32'hCCCC_CCCC, 32'd1);

      // capacity lowered below the bytes held: credit saturates at zero
      write_capacity(32'd50);
      send_word(OPC_STATUS, '0, '0, '0, '0);
      send_word(OPC_GET, '0, '0, '0, '0);
      send_word(OPC_GET, '0, '0, '0, '0);
      send_word(OPC_GET, '0, '0, '0, '0);

      random_phase('0, 0);
      random_phase(32'd1000, 61);
      random_phase(ALL_ONES, 25);
      random_phase(32'd1, 0);
      random_phase($urandom, 61);
      random_phase(32'd300, 25);

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[byte_credit_fifo_unit] OK");
      end else begin
         $display("[byte_credit_fifo_unit] ERROR");
      end
      $finish;
   end

endmodule
